>>> rtl/wcs_pkg.sv
// Shared constants and controller/datapath interface types for the category sampler.
package wcs_pkg;

    localparam int MAX_CATEGORIES = 1024;
    localparam int WEIGHT_BITS    = 32;

    localparam int DRAW_W   = 32;
    localparam int CAT_W    = 11;
    localparam int CNT_W    = $clog2(MAX_CATEGORIES + 1);
    localparam int IDX_W    = $clog2(MAX_CATEGORIES);
    localparam int TOT_W    = WEIGHT_BITS + IDX_W;
    localparam int TOT_HI_W = (TOT_W > DRAW_W) ? (TOT_W - DRAW_W) : 1;
    localparam int TOTX_W   = DRAW_W + TOT_HI_W;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_THR,
        S_SRCH
    } t_state;

    typedef struct packed {
        logic load;
        logic query;
        logic mul;
        logic thr;
        logic srch;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic srch_done;
    } t_dp_stat;

endpackage

>>> rtl/wcs_ctrl.sv
// Sequencer for loads and queries, plus the output valid register.
module wcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_func,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  wcs_pkg::t_dp_stat i_stat,
    output wcs_pkg::t_dp_cmd  o_cmd
);
    import wcs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_QUERY) begin
                        o_cmd.query = 1'b1;
                        n_state     = S_MUL;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_THR;
            end
            S_THR: begin
                o_cmd.thr = 1'b1;
                n_state   = S_SRCH;
            end
            S_SRCH: begin
                o_cmd.srch = 1'b1;
                // hold the finished index until the output register frees up
                if (i_stat.srch_done && out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

>>> rtl/wcs_dpath.sv
// Prefix-sum memory, table bookkeeping, threshold multiply and binary search.
module wcs_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wcs_pkg::t_dp_cmd          i_cmd,
    output wcs_pkg::t_dp_stat         o_stat,
    input  logic                      i_new_set,
    input  logic [31:0]               i_weight,
    input  logic [wcs_pkg::DRAW_W-1:0] i_draw,
    output logic [wcs_pkg::CAT_W-1:0] o_category,
    output logic                      o_overflow
);
    import wcs_pkg::*;

    logic [TOT_W-1:0]  r_mem [MAX_CATEGORIES];
    logic [TOT_W-1:0]  r_rd;

    logic [CNT_W-1:0]  r_count;
    logic [TOT_W-1:0]  r_total;
    logic              r_ovf;

    logic [DRAW_W-1:0]   r_draw;
    logic [2*DRAW_W-1:0] r_prod_lo;
    logic [TOTX_W-1:0]   r_prod_hi;
    logic [TOTX_W-1:0]   r_thr;

    logic [CNT_W-1:0]  r_lo, r_hi, r_mid;
    logic [CNT_W-1:0]  n_lo, n_hi, n_mid;
    logic [CNT_W-1:0]  span;

    logic [CAT_W-1:0]  r_category;
    logic              r_overflow;

    // load path
    logic [CNT_W-1:0]  base_cnt;
    logic [TOT_W-1:0]  base_tot;
    logic [TOT_W-1:0]  sum_tot;
    logic              full;

    logic [TOTX_W-1:0] tot_x;
    logic              hit;

    assign base_cnt = i_new_set ? '0 : r_count;
    assign base_tot = i_new_set ? '0 : r_total;
    assign sum_tot  = base_tot + TOT_W'(i_weight[WEIGHT_BITS-1:0]);
    assign full     = (base_cnt >= CNT_W'(MAX_CATEGORIES));

    assign tot_x = TOTX_W'(r_total);
    assign hit   = (TOTX_W'(r_rd) >= r_thr);

    assign o_stat.srch_done = (r_lo >= r_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load) begin
            if (full) begin
                r_count <= base_cnt;
                r_total <= base_tot;
                r_ovf   <= 1'b1;
            end else begin
                r_count <= base_cnt + CNT_W'(1);
                r_total <= sum_tot;
                r_ovf   <= i_new_set ? 1'b0 : r_ovf;
            end
        end
    end

    // search bounds: start over the whole table, then halve per step
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.thr) begin
            n_lo = '0;
            n_hi = r_count;
        end else if (i_cmd.srch && (r_lo < r_hi)) begin
            if (hit) begin
                n_hi = r_mid;
            end else begin
                n_lo = r_mid + CNT_W'(1);
            end
        end
        span  = n_hi - n_lo;
        n_mid = n_lo + (span >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            r_mem[base_cnt[IDX_W-1:0]] <= sum_tot;
        end
        r_rd <= r_mem[n_mid[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_draw <= i_draw;
        end
        if (i_cmd.mul) begin
            r_prod_lo <= (2*DRAW_W)'(r_draw) * (2*DRAW_W)'(tot_x[DRAW_W-1:0]);
            r_prod_hi <= TOTX_W'(r_draw) * TOTX_W'(tot_x[TOTX_W-1:DRAW_W]);
        end
        if (i_cmd.thr) begin
            // ceiling of draw * total / 2^32
            r_thr <= r_prod_hi + TOTX_W'(r_prod_lo[2*DRAW_W-1:DRAW_W])
                     + TOTX_W'(|r_prod_lo[DRAW_W-1:0]);
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        if (i_cmd.out_load) begin
            r_category <= CAT_W'(r_lo + CNT_W'(1));
            r_overflow <= r_ovf;
        end
    end

    assign o_category = r_category;
    assign o_overflow = r_overflow;

endmodule

>>> rtl/weighted_category_sampler.sv
// Top level of the inverse-CDF category sampler: controller plus datapath.
//
//  channel  direction  handshake           payload
//  request  in         i_valid / o_stall   i_func, i_new_set, i_weight, i_draw
//  result   out        o_valid / i_stall   o_category, o_overflow
//
// A load request writes one prefix-sum entry, or sets the overflow flag if the table is full.
// A query runs from acceptance to the result register through the multiply, the threshold
// add, one binary-search step per cycle through the registered prefix memory read, then
// the hand-off. A finished result waits in the output register while i_stall is high;
// the next request is taken the cycle after the hand-off.
// Synchronous active-low reset clears the count, total, overflow flag and control.
module weighted_category_sampler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_func,
    input  logic                       i_new_set,
    input  logic [31:0]                i_weight,
    input  logic [wcs_pkg::DRAW_W-1:0] i_draw,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [wcs_pkg::CAT_W-1:0]  o_category,
    output logic                       o_overflow
);
    import wcs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    wcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    wcs_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_new_set  (i_new_set),
        .i_weight   (i_weight),
        .i_draw     (i_draw),
        .o_category (o_category),
        .o_overflow (o_overflow)
    );

endmodule
